// File: rtl/blpd_pkg.sv
package blpd_pkg;

   localparam int DEFAULT_TABLE_DEPTH = 16;
   localparam int TABLE_SIZE          = 16;

   localparam logic [1:0] MODE_BREATH = 2'd0;
   localparam logic [1:0] MODE_FLASH  = 2'd1;
   localparam logic [1:0] MODE_OFF    = 2'd2;

   localparam logic [1:0] CSR_MODE      = 2'd0;
   localparam logic [1:0] CSR_PERIOD    = 2'd1;
   localparam logic [1:0] CSR_THRESHOLD = 2'd2;

   localparam logic [1:0]  RESET_MODE      = MODE_OFF;
   localparam logic [15:0] RESET_PERIOD    = 16'd9216;
   localparam logic [7:0]  RESET_THRESHOLD = 8'd10;
   localparam logic [3:0]  RESET_DUTY_SEL  = 4'd2;
   localparam int          RESET_DUTY      = 10;
   localparam int          PERCENT         = 100;
   localparam logic [15:0] RESET_PHASE_LEN = 16'(int'(RESET_PERIOD) * RESET_DUTY / PERCENT);

   // floor(x / 100) = (x * DIV100_MUL) >> DIV100_SHIFT for x < 2**23
   localparam logic [23:0] DIV100_MUL   = 24'd10737419;
   localparam int          DIV100_SHIFT = 30;

   typedef struct packed {
      logic [1:0]  mode;
      logic [15:0] period;
      logic [7:0]  threshold;
   } cfg_type;

   typedef struct packed {
      logic       wr;
      logic [1:0] value;
   } mode_wr_type;

   function automatic logic [6:0] breath_duty(input logic [3:0] idx);
      logic [6:0] d;
      case (idx)
         4'd0:    d = 7'd1;
         4'd1:    d = 7'd5;
         4'd2:    d = 7'd10;
         4'd3:    d = 7'd18;
         4'd4:    d = 7'd23;
         4'd5:    d = 7'd30;
         4'd6:    d = 7'd41;
         4'd7:    d = 7'd51;
         4'd8:    d = 7'd60;
         4'd9:    d = 7'd68;
         4'd10:   d = 7'd75;
         4'd11:   d = 7'd81;
         4'd12:   d = 7'd86;
         4'd13:   d = 7'd90;
         4'd14:   d = 7'd93;
         4'd15:   d = 7'd95;
         default: d = 7'd95;
      endcase
      return d;
   endfunction

endpackage

// File: rtl/blpd_hlen_table.sv
module blpd_hlen_table (
   input  logic        clock,
   input  logic        reset,
   input  logic [15:0] period,
   input  logic        restart,
   input  logic [3:0]  rd_idx,
   output logic [15:0] rd_len,
   output logic        busy
);

   logic        active_ff, active_in;
   logic [3:0]  idx_ff, idx_in;
   logic        s1_valid_ff, s1_valid_in;
   logic [3:0]  s1_idx_ff;
   logic [22:0] s1_prod_ff;
   logic [15:0] len_ff [blpd_pkg::TABLE_SIZE];
   logic [46:0] quot_wide;

   always_comb begin
      active_in   = active_ff;
      idx_in      = idx_ff;
      s1_valid_in = active_ff;
      if (active_ff) begin
         if (idx_ff == 4'(blpd_pkg::TABLE_SIZE - 1)) begin
            active_in = 1'b0;
         end
         idx_in = idx_ff + 4'd1;
      end
      if (restart) begin
         active_in = 1'b1;
         idx_in    = 4'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= 1'b1;
         idx_ff      <= 4'd0;
         s1_valid_ff <= 1'b0;
      end else begin
         active_ff   <= active_in;
         idx_ff      <= idx_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   // period times table duty
   always_ff @(posedge clock) begin
      s1_idx_ff  <= idx_ff;
      s1_prod_ff <= 23'(period) * 23'(blpd_pkg::breath_duty(idx_ff));
   end

   // divide by 100 through reciprocal
   assign quot_wide = 47'(s1_prod_ff) * 47'(blpd_pkg::DIV100_MUL);

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         len_ff[s1_idx_ff] <= quot_wide[blpd_pkg::DIV100_SHIFT +: 16];
      end
   end

   assign rd_len = len_ff[rd_idx];
   assign busy   = active_ff || s1_valid_ff;

endmodule

// File: rtl/blpd_core.sv
module blpd_core #(
   parameter int TABLE_DEPTH = blpd_pkg::DEFAULT_TABLE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  blpd_pkg::cfg_type     cfg,
   input  blpd_pkg::mode_wr_type mode_wr,
   input  logic                  hold,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_count_tick,
   input  logic                  req_step_tick,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_led_pin,
   output logic [6:0]            rsp_duty_now,
   output logic [3:0]            rsp_table_pos,
   output logic [3:0]            hl_rd_idx,
   input  logic [15:0]           hl_rd_len
);

   localparam int POS_W = $clog2(TABLE_DEPTH);

   logic             a_valid_ff, a_valid_in;
   logic             a_count_ff, a_step_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_pin_ff;
   logic [6:0]       rsp_duty_ff;
   logic [3:0]       rsp_pos_ff;

   logic             pin_ff, pin_in;
   logic [15:0]      pc_ff, pc_in;
   logic [15:0]      plen_ff, plen_in;
   logic [3:0]       dsel_ff, dsel_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             falling_ff, falling_in;
   logic [7:0]       fc_ff, fc_in;

   logic             advance;
   logic             work;
   logic [15:0]      pc_inc;
   logic [8:0]       fc_inc;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign work      = a_valid_ff && advance;
   assign req_ready = !hold && (!a_valid_ff || advance);

   always_comb begin
      a_valid_in   = a_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         a_valid_in   = 1'b0;
         rsp_valid_in = a_valid_ff;
      end
      if (req_valid && req_ready) begin
         a_valid_in = 1'b1;
      end
   end

   always_comb begin
      pin_in     = pin_ff;
      pc_in      = pc_ff;
      plen_in    = plen_ff;
      dsel_in    = dsel_ff;
      pos_in     = pos_ff;
      falling_in = falling_ff;
      fc_in      = fc_ff;
      pc_inc     = pc_ff + 16'd1;
      fc_inc     = 9'(fc_ff) + 9'd1;

      if (mode_wr.wr) begin
         if (mode_wr.value == blpd_pkg::MODE_FLASH) begin
            pin_in = 1'b0;
         end else if (mode_wr.value != blpd_pkg::MODE_BREATH) begin
            pin_in = 1'b1;
         end
      end

      if (work) begin
         if (cfg.mode == blpd_pkg::MODE_BREATH) begin
            if (a_step_ff) begin
               // index past the table reads the last entry
               if (7'(pos_ff) >= 7'(blpd_pkg::TABLE_SIZE)) begin
                  dsel_in = 4'(blpd_pkg::TABLE_SIZE - 1);
               end else begin
                  dsel_in = 4'(pos_ff);
               end
               if (!falling_ff) begin
                  pos_in = pos_ff + POS_W'(1);
                  if (pos_in >= POS_W'(TABLE_DEPTH - 1)) begin
                     falling_in = 1'b1;
                  end
               end else begin
                  if (pos_ff != '0) begin
                     pos_in = pos_ff - POS_W'(1);
                  end
                  if (pos_in == '0) begin
                     falling_in = 1'b0;
                  end
               end
            end
            if (a_count_ff) begin
               pc_in = pc_inc;
               // zero length phase ends after one count
               if (pc_inc >= plen_ff || pc_inc == 16'd0) begin
                  pc_in = 16'd0;
                  if (pin_ff) begin
                     pin_in  = 1'b0;
                     plen_in = cfg.period - hl_rd_len;
                  end else begin
                     pin_in  = 1'b1;
                     plen_in = hl_rd_len;
                  end
               end
            end
         end else if (cfg.mode == blpd_pkg::MODE_FLASH) begin
            if (a_step_ff) begin
               if (fc_inc > 9'(cfg.threshold)) begin
                  fc_in  = 8'd0;
                  pin_in = !pin_ff;
               end else begin
                  fc_in = fc_inc[7:0];
               end
            end
         end else begin
            pin_in = 1'b1;
         end
      end
   end

   assign hl_rd_idx = dsel_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pin_ff       <= 1'b1;
         pc_ff        <= 16'd0;
         plen_ff      <= blpd_pkg::RESET_PHASE_LEN;
         dsel_ff      <= blpd_pkg::RESET_DUTY_SEL;
         pos_ff       <= '0;
         falling_ff   <= 1'b0;
         fc_ff        <= 8'd0;
      end else begin
         a_valid_ff   <= a_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         pin_ff       <= pin_in;
         pc_ff        <= pc_in;
         plen_ff      <= plen_in;
         dsel_ff      <= dsel_in;
         pos_ff       <= pos_in;
         falling_ff   <= falling_in;
         fc_ff        <= fc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         a_count_ff <= req_count_tick;
         a_step_ff  <= req_step_tick;
      end
      if (work) begin
         rsp_pin_ff  <= pin_in;
         rsp_duty_ff <= blpd_pkg::breath_duty(dsel_in);
         rsp_pos_ff  <= 4'(pos_in);
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_led_pin   = rsp_pin_ff;
   assign rsp_duty_now  = rsp_duty_ff;
   assign rsp_table_pos = rsp_pos_ff;

endmodule

// File: rtl/breathing_led_pwm_driver_top.sv
// channel  | direction | beat contents
// ---------+-----------+--------------------------------------------
// req_     | in        | count_tick, step_tick
// rsp_     | out       | led_pin, duty_now, table_pos
// csr_     | in        | index (0 mode, 1 period_count, 2 flash_threshold), data
//
// one beat per cycle while req_ready is high; each accepted req beat passes an
// input register, then an output register that drives rsp_valid, so req is
// decoupled from rsp stalls; after reset, and after each period_count write, a
// sweep fills the high length table (16 entries, one multiply pair per entry)
// with req_ready low; synchronous active high reset; csr_ready is always high
module breathing_led_pwm_driver_top #(
   parameter int TABLE_DEPTH = blpd_pkg::DEFAULT_TABLE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_count_tick,
   input  logic        req_step_tick,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_led_pin,
   output logic [6:0]  rsp_duty_now,
   output logic [3:0]  rsp_table_pos,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   logic [1:0]            mode_ff;
   logic [15:0]           period_ff;
   logic [7:0]            thresh_ff;
   logic                  csr_wr;
   blpd_pkg::cfg_type     cfg;
   blpd_pkg::mode_wr_type mode_wr;
   logic                  restart;
   logic                  busy;
   logic [3:0]            hl_rd_idx;
   logic [15:0]           hl_rd_len;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= blpd_pkg::RESET_MODE;
         period_ff <= blpd_pkg::RESET_PERIOD;
         thresh_ff <= blpd_pkg::RESET_THRESHOLD;
      end else if (csr_wr) begin
         case (csr_index)
            blpd_pkg::CSR_MODE:      mode_ff   <= csr_data[1:0];
            blpd_pkg::CSR_PERIOD:    period_ff <= csr_data;
            blpd_pkg::CSR_THRESHOLD: thresh_ff <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   assign cfg.mode      = mode_ff;
   assign cfg.period    = period_ff;
   assign cfg.threshold = thresh_ff;

   assign mode_wr.wr    = csr_wr && (csr_index == blpd_pkg::CSR_MODE);
   assign mode_wr.value = csr_data[1:0];

   assign restart = csr_wr && (csr_index == blpd_pkg::CSR_PERIOD);

   blpd_hlen_table u_hlen_table (
      .clock   (clock),
      .reset   (reset),
      .period  (period_ff),
      .restart (restart),
      .rd_idx  (hl_rd_idx),
      .rd_len  (hl_rd_len),
      .busy    (busy)
   );

   blpd_core #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_core (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .mode_wr        (mode_wr),
      .hold           (busy),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_count_tick (req_count_tick),
      .req_step_tick  (req_step_tick),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_led_pin    (rsp_led_pin),
      .rsp_duty_now   (rsp_duty_now),
      .rsp_table_pos  (rsp_table_pos),
      .hl_rd_idx      (hl_rd_idx),
      .hl_rd_len      (hl_rd_len)
   );

endmodule

// File: test/tb_breathing_led_pwm_driver_top.sv
`timescale 1ns / 100ps

module tb_breathing_led_pwm_driver_top;

   localparam logic [1:0] MODE_SPARE  = 2'd3;
   localparam logic [1:0] CSR_UNUSED  = 2'd3;
   localparam int         HOLD_CYCLES   = 300;
   localparam int         SETTLE_CYCLES = 4;
   localparam int         STUCK_LIMIT   = 3000;
   localparam logic [16*7-1:0] DUTY_STEPS = {
      7'd95, 7'd93, 7'd90, 7'd86, 7'd81, 7'd75, 7'd68, 7'd60,
      7'd51, 7'd41, 7'd30, 7'd23, 7'd18, 7'd10, 7'd5, 7'd1
   };

   typedef struct packed {
      logic count;
      logic step;
   } tick_type;

   typedef struct packed {
      logic       pin;
      logic [6:0] duty;
      logic [3:0] pos;
   } led_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_count_tick = 1'b0;
   logic        req_step_tick = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_led_pin;
   logic [6:0]  rsp_duty_now;
   logic [3:0]  rsp_table_pos;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   // expected led state, tracked at each accepted beat
   logic [1:0]  cfg_mode;
   logic [15:0] cfg_period;
   logic [7:0]  cfg_thresh;
   logic        st_pin;
   logic [15:0] st_phase_cnt;
   logic [15:0] st_phase_len;
   logic [6:0]  st_duty;
   logic [5:0]  st_pos;
   logic        st_falling;
   logic [7:0]  st_flash_cnt;

   tick_type     tick_q[$];
   led_beat_type led_beats_q[$];
   tick_type     launch_tick;
   led_beat_type want_beat;

   logic idle_on = 1'b0;
   int   burst_left = 0;
   int   gap_left = 0;
   int   ready_run = 0;
   int   hold_req = 0;
   int   hold_ack = 0;
   int   hold_left = 0;
   int   stuck_cycles = 0;
   int   fail_count = 0;

   breathing_led_pwm_driver_top u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_count_tick (req_count_tick),
      .req_step_tick  (req_step_tick),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_led_pin    (rsp_led_pin),
      .rsp_duty_now   (rsp_duty_now),
      .rsp_table_pos  (rsp_table_pos),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [15:0] high_counts();
      logic [31:0] prod;
      prod = cfg_period * st_duty;
      return 16'(prod / blpd_pkg::PERCENT);
   endfunction

   function automatic void reset_led_state();
      cfg_mode     = blpd_pkg::RESET_MODE;
      cfg_period   = blpd_pkg::RESET_PERIOD;
      cfg_thresh   = blpd_pkg::RESET_THRESHOLD;
      st_pin       = 1'b1;
      st_phase_cnt = '0;
      st_duty      = 7'(blpd_pkg::RESET_DUTY);
      st_phase_len = high_counts();
      st_pos       = '0;
      st_falling   = 1'b0;
      st_flash_cnt = '0;
   endfunction

   function automatic void apply_reg_write(input logic [1:0] idx, input logic [15:0] data);
      case (idx)
         blpd_pkg::CSR_MODE: begin
            cfg_mode = data[1:0];
            if (cfg_mode == blpd_pkg::MODE_FLASH) begin
               st_pin = 1'b0;
            end else if (cfg_mode == blpd_pkg::MODE_OFF || cfg_mode == MODE_SPARE) begin
               st_pin = 1'b1;
            end
         end
         blpd_pkg::CSR_PERIOD:    cfg_period = data;
         blpd_pkg::CSR_THRESHOLD: cfg_thresh = data[7:0];
         default: ;
      endcase
   endfunction

   function automatic void advance_led(input logic count, input logic step);
      logic [5:0]   idx;
      logic [8:0]   flash_next;
      led_beat_type beat;
      if (cfg_mode == blpd_pkg::MODE_BREATH) begin
         if (step) begin
            idx = (st_pos < blpd_pkg::TABLE_SIZE) ? st_pos : 6'(blpd_pkg::TABLE_SIZE - 1);
            st_duty = DUTY_STEPS[idx*7 +: 7];
            if (!st_falling) begin
               st_pos = st_pos + 6'd1;
               if (st_pos >= blpd_pkg::DEFAULT_TABLE_DEPTH - 1) st_falling = 1'b1;
            end else begin
               if (st_pos != 0) st_pos = st_pos - 6'd1;
               if (st_pos == 0) st_falling = 1'b0;
            end
         end
         if (count) begin
            st_phase_cnt = st_phase_cnt + 16'd1;
            if (st_phase_cnt >= st_phase_len || st_phase_cnt == 16'd0) begin
               st_phase_cnt = '0;
               if (st_pin) begin
                  st_pin = 1'b0;
                  st_phase_len = cfg_period - high_counts();
               end else begin
                  st_pin = 1'b1;
                  st_phase_len = high_counts();
               end
            end
         end
      end else if (cfg_mode == blpd_pkg::MODE_FLASH) begin
         if (step) begin
            flash_next = {1'b0, st_flash_cnt} + 9'd1;
            if (flash_next > {1'b0, cfg_thresh}) begin
               st_flash_cnt = '0;
               st_pin = ~st_pin;
            end else begin
               st_flash_cnt = flash_next[7:0];
            end
         end
      end else begin
         st_pin = 1'b1;
      end
      beat.pin  = st_pin;
      beat.duty = st_duty;
      beat.pos  = st_pos[3:0];
      led_beats_q.push_back(beat);
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("ERROR %0t: %s got %0d expected %0d", $time, what, got, want);
      fail_count++;
   endtask

   // tick sender, bursts with gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid      <= 1'b0;
         req_count_tick <= 1'b0;
         req_step_tick  <= 1'b0;
         burst_left     <= 0;
         gap_left       <= 0;
      end else begin
         if (req_valid && req_ready) advance_led(req_count_tick, req_step_tick);
         if (!req_valid || req_ready) begin
            if (gap_left != 0 || tick_q.size() == 0) begin
               req_valid <= 1'b0;
               if (gap_left != 0) gap_left <= gap_left - 1;
            end else begin
               launch_tick = tick_q.pop_front();
               req_valid      <= 1'b1;
               req_count_tick <= launch_tick.count;
               req_step_tick  <= launch_tick.step;
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 16);
                  gap_left   <= idle_on ? $urandom_range(1, 8) : 0;
               end else begin
                  burst_left <= burst_left - 1;
               end
            end
         end
      end
   end

   // result receiver with its own stall runs and an occasional long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         ready_run <= 0;
         hold_ack  <= hold_req;
         hold_left <= 0;
      end else if (hold_ack != hold_req) begin
         hold_ack  <= hold_req;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (ready_run != 0) begin
         ready_run <= ready_run - 1;
      end else if (!idle_on || !rsp_ready) begin
         rsp_ready <= 1'b1;
         ready_run <= $urandom_range(0, 9);
      end else begin
         rsp_ready <= 1'b0;
         ready_run <= $urandom_range(0, 4);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (led_beats_q.size() == 0) begin
            report_mismatch("beat with nothing pending, led_pin", rsp_led_pin, 0);
         end else begin
            want_beat = led_beats_q.pop_front();
            if (rsp_led_pin !== want_beat.pin)
               report_mismatch("led_pin", rsp_led_pin, want_beat.pin);
            if (rsp_duty_now !== want_beat.duty)
               report_mismatch("duty_now", rsp_duty_now, want_beat.duty);
            if (rsp_table_pos !== want_beat.pos)
               report_mismatch("table_pos", rsp_table_pos, want_beat.pos);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         stuck_cycles <= 0;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
         if (stuck_cycles == STUCK_LIMIT) begin
            $display("breathing_led_pwm_driver_top regression: fail");
            $finish;
         end
      end
   end

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      apply_reg_write(idx, data);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic push_tick(input logic count, input logic step);
      tick_type t;
      t.count = count;
      t.step  = step;
      tick_q.push_back(t);
   endtask

   task automatic push_random(input int n, input int count_pct, input int step_pct);
      tick_type t;
      repeat (n) begin
         t.count = ($urandom_range(0, 99) < count_pct);
         t.step  = ($urandom_range(0, 99) < step_pct);
         tick_q.push_back(t);
      end
   endtask

   task automatic settle();
      do @(negedge clock); while (tick_q.size() != 0 || req_valid || led_beats_q.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      reset_led_state();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // off mode straight out of reset
      push_tick(1'b0, 1'b0);
      push_tick(1'b1, 1'b0);
      push_tick(1'b0, 1'b1);
      push_tick(1'b1, 1'b1);
      settle();

      write_reg(blpd_pkg::CSR_THRESHOLD, 16'd1);
      write_reg(blpd_pkg::CSR_MODE, 16'(blpd_pkg::MODE_FLASH));
      repeat (4) push_tick(1'b0, 1'b1);
      push_tick(1'b1, 1'b0);
      push_tick(1'b1, 1'b1);
      settle();

      // mode 3 acts as off, unused index is dropped
      write_reg(blpd_pkg::CSR_MODE, 16'hFFFF);
      push_tick(1'b1, 1'b1);
      push_tick(1'b0, 1'b1);
      settle();
      write_reg(CSR_UNUSED, 16'hFFFF);
      push_tick(1'b0, 1'b1);
      settle();

      write_reg(blpd_pkg::CSR_MODE, 16'hABCD);
      write_reg(blpd_pkg::CSR_THRESHOLD, 16'h5A03);
      repeat (5) push_tick(1'b0, 1'b1);
      settle();

      // steps walk the table up and down while the reset-time high phase counts
      idle_on = 1'b1;
      write_reg(blpd_pkg::CSR_PERIOD, 16'd3);
      write_reg(blpd_pkg::CSR_MODE, 16'(blpd_pkg::MODE_BREATH));
      push_random(120, 90, 30);
      settle();

      // very short periods
      write_reg(blpd_pkg::CSR_PERIOD, 16'd0);
      push_random(20, 70, 30);
      settle();
      write_reg(blpd_pkg::CSR_PERIOD, 16'd1);
      push_random(20, 70, 30);
      settle();

      // receiver holds off while ticks keep coming
      write_reg(blpd_pkg::CSR_PERIOD, 16'd20);
      write_reg(blpd_pkg::CSR_THRESHOLD, 16'($urandom()));
      idle_on = 1'b0;
      push_random(80, 80, 40);
      hold_req = hold_req + 1;
      settle();
      idle_on = 1'b1;

      // flash at the top threshold needs a 9-bit compare
      write_reg(blpd_pkg::CSR_THRESHOLD, 16'd255);
      write_reg(blpd_pkg::CSR_MODE, 16'(blpd_pkg::MODE_FLASH));
      push_random(270, 50, 100);
      settle();

      write_reg(blpd_pkg::CSR_MODE, 16'(blpd_pkg::MODE_OFF));
      push_random(10, 50, 50);
      settle();

      idle_on = 1'b0;
      write_reg(blpd_pkg::CSR_PERIOD, 16'd100);
      write_reg(blpd_pkg::CSR_MODE, 16'(blpd_pkg::MODE_BREATH));
      push_random(40, 90, 20);
      settle();
      idle_on = 1'b1;

      write_reg(blpd_pkg::CSR_THRESHOLD, 16'($urandom_range(1, 8)));
      write_reg(blpd_pkg::CSR_MODE, 16'(blpd_pkg::MODE_FLASH));
      push_random(30, 50, 60);
      settle();

      // pwm state resumes after a detour through mode 3
      write_reg(blpd_pkg::CSR_MODE, 16'(MODE_SPARE));
      push_random(10, 50, 50);
      settle();
      write_reg(blpd_pkg::CSR_PERIOD, 16'($urandom_range(2, 30)));
      write_reg(blpd_pkg::CSR_MODE, 16'(blpd_pkg::MODE_BREATH));
      push_random(30, 80, 30);
      settle();

      write_reg(blpd_pkg::CSR_PERIOD, 16'hFFFF);
      push_random(20, 80, 50);
      settle();

      if (fail_count == 0) begin
         $display("breathing_led_pwm_driver_top regression: pass");
      end else begin
         $display("breathing_led_pwm_driver_top regression: fail");
      end
      $finish;
   end

endmodule
